// ===== rtl/hoe_pkg.sv =====
// Shared types, constants and helpers for the Hall Ohm electric field pipeline.
// No dependencies.
package hoe_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int ICR_W         = 31;
	localparam logic [ICR_W-1:0] ICR_RESET = 31'd65536;
	localparam int QUO_W         = 32;
	localparam int DIV_BITS_STG  = 2;
	localparam int DIV_STAGES    = QUO_W / DIV_BITS_STG;
	localparam int DIV_LAT       = DIV_STAGES + 2;
	localparam int NUM_LAT       = 2;
	localparam int CRS_LAT       = 2;
	localparam int MAG_W         = 63;

	typedef logic signed [31:0] word_t;

	typedef struct packed {
		word_t b_x;
		word_t b_y;
		word_t b_z;
		word_t j_x;
		word_t j_y;
		word_t j_z;
		word_t density;
		word_t mom_x;
		word_t mom_y;
		word_t mom_z;
	} in_beat_t;

	typedef struct packed {
		word_t e_x;
		word_t e_y;
		word_t e_z;
		logic  bad_density;
	} out_beat_t;

	typedef struct packed {
		word_t x;
		word_t y;
		word_t z;
	} vec_t;

	typedef struct packed {
		logic [2:0]       neg;
		logic [MAG_W-1:0] mag_x;
		logic [MAG_W-1:0] mag_y;
		logic [MAG_W-1:0] mag_z;
		logic [30:0]      rho;
		vec_t             b;
		logic             bad;
	} num_t;

	function automatic word_t sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647)
			sat32 = 32'sh7fffffff;
		else if (x < -64'sd2147483648)
			sat32 = 32'sh80000000;
		else
			sat32 = word_t'(x[31:0]);
	endfunction
endpackage

// ===== rtl/hoe_numer.sv =====
// Numerator stages: scaled current, momentum difference, clamp, sign/magnitude.
// Depends on hoe_pkg.
module hoe_numer import hoe_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             en,
	input  logic [ICR_W-1:0] icr,
	input  in_beat_t         beat,
	output num_t             num
);
	localparam logic signed [63:0] LIM = 64'sd1 <<< (62 - FRAC_BITS);

	logic signed [63:0] prod_s1 [3];
	word_t              mom_s1  [3];
	logic [30:0]        rho_s1;
	vec_t               b_s1;
	logic               bad_s1;

	word_t              j_w   [3];
	word_t              m_w   [3];
	logic [MAG_W-1:0]   mag_w [3];
	logic [2:0]         neg_w;

	assign j_w[0] = beat.j_x;
	assign j_w[1] = beat.j_y;
	assign j_w[2] = beat.j_z;
	assign m_w[0] = beat.mom_x;
	assign m_w[1] = beat.mom_y;
	assign m_w[2] = beat.mom_z;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				prod_s1[k] <= $signed({1'b0, icr}) * j_w[k];
				mom_s1[k]  <= m_w[k];
			end
			rho_s1 <= beat.density[30:0];
			b_s1   <= '{x: beat.b_x, y: beat.b_y, z: beat.b_z};
			bad_s1 <= (beat.density <= 0);
		end
	end

	always_comb begin
		logic signed [63:0] p;
		logic signed [63:0] n;
		logic signed [63:0] s;
		for (int k = 0; k < 3; k++) begin
			p = prod_s1[k] >>> FRAC_BITS;
			n = 64'(mom_s1[k]) - p;
			if (n > LIM)
				n = LIM;
			if (n < -LIM)
				n = -LIM;
			s = n <<< FRAC_BITS;
			neg_w[k] = s[63];
			mag_w[k] = s[63] ? MAG_W'(-s) : MAG_W'(s);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num.neg   <= neg_w;
			num.mag_x <= mag_w[0];
			num.mag_y <= mag_w[1];
			num.mag_z <= mag_w[2];
			num.rho   <= rho_s1;
			num.b     <= b_s1;
			num.bad   <= bad_s1;
		end
	end
endmodule

// ===== rtl/hoe_div.sv =====
// Pipelined restoring divider, DIV_BITS_STG quotient bits per stage, saturated result.
// Depends on hoe_pkg.
module hoe_div import hoe_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [MAG_W-1:0] mag,
	input  logic [30:0]      rho,
	input  logic             neg,
	output word_t            quo
);
	logic [30:0]      rem_s [DIV_STAGES+1];
	logic [QUO_W-1:0] low_s [DIV_STAGES+1];
	logic [QUO_W-1:0] q_s   [DIV_STAGES+1];
	logic [30:0]      rho_s [DIV_STAGES+1];
	logic             neg_s [DIV_STAGES+1];
	logic             ovf_s [DIV_STAGES+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= mag[MAG_W-1:QUO_W];
			low_s[0] <= mag[QUO_W-1:0];
			q_s[0]   <= '0;
			rho_s[0] <= rho;
			neg_s[0] <= neg;
			ovf_s[0] <= (mag[MAG_W-1:QUO_W] >= rho);
		end
	end

	for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_stg
		logic [30:0]      r_w;
		logic [QUO_W-1:0] lo_w;
		logic [QUO_W-1:0] q_w;

		always_comb begin
			logic [31:0] r2;
			r_w  = rem_s[g-1];
			lo_w = low_s[g-1];
			q_w  = q_s[g-1];
			for (int b = 0; b < DIV_BITS_STG; b++) begin
				r2   = {r_w, lo_w[QUO_W-1]};
				lo_w = {lo_w[QUO_W-2:0], 1'b0};
				if (r2 >= {1'b0, rho_s[g-1]}) begin
					r_w = 31'(r2 - {1'b0, rho_s[g-1]});
					q_w = {q_w[QUO_W-2:0], 1'b1};
				end else begin
					r_w = r2[30:0];
					q_w = {q_w[QUO_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= r_w;
				low_s[g] <= lo_w;
				q_s[g]   <= q_w;
				rho_s[g] <= rho_s[g-1];
				neg_s[g] <= neg_s[g-1];
				ovf_s[g] <= ovf_s[g-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [QUO_W-1:0] q;
		q = q_s[DIV_STAGES];
		if (en) begin
			if (!neg_s[DIV_STAGES]) begin
				if (ovf_s[DIV_STAGES] || q[QUO_W-1])
					quo <= 32'sh7fffffff;
				else
					quo <= word_t'(q);
			end else begin
				if (ovf_s[DIV_STAGES] || (q[QUO_W-1] && (q[QUO_W-2:0] != '0)))
					quo <= 32'sh80000000;
				else
					quo <= word_t'(-q);
			end
		end
	end
endmodule

// ===== rtl/hoe_cross.sv =====
// Cross product B x U: six products, then difference, floor shift and saturation.
// Depends on hoe_pkg.
module hoe_cross import hoe_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      en,
	input  vec_t      u,
	input  vec_t      b,
	input  logic      bad,
	output out_beat_t res
);
	logic signed [63:0] pr_s1 [6];
	logic               bad_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s1[0] <= u.z * b.y;
			pr_s1[1] <= u.y * b.z;
			pr_s1[2] <= u.x * b.z;
			pr_s1[3] <= u.z * b.x;
			pr_s1[4] <= u.y * b.x;
			pr_s1[5] <= u.x * b.y;
			bad_s1   <= bad;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.bad_density <= bad_s1;
			if (bad_s1) begin
				res.e_x <= '0;
				res.e_y <= '0;
				res.e_z <= '0;
			end else begin
				res.e_x <= sat32((pr_s1[0] - pr_s1[1]) >>> FRAC_BITS);
				res.e_y <= sat32((pr_s1[2] - pr_s1[3]) >>> FRAC_BITS);
				res.e_z <= sat32((pr_s1[4] - pr_s1[5]) >>> FRAC_BITS);
			end
		end
	end
endmodule

// ===== rtl/hall_ohm_electric_field_top.sv =====
// Hall MHD Ohm's law electric field, one grid cell per beat.
// Stages in order: numerator, pipelined divider, cross product.
// Throughput one beat per cycle; the whole pipeline holds while the output waits.
// Reset clears the valid bits and sets inverse_charge_ratio to 1.0.
// Depends on hoe_pkg, hoe_numer, hoe_div, hoe_cross.
module hall_ohm_electric_field_top import hoe_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_beat_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_beat_t        out_data,
	input  logic             cfg_we,
	input  logic [ICR_W-1:0] cfg_wdata
);
	localparam int LAT = NUM_LAT + DIV_LAT + CRS_LAT;

	logic [ICR_W-1:0] icr_q;
	logic [LAT-1:0]   vld_q;
	logic             en;
	num_t             num;
	vec_t             u;
	vec_t             b_dly_q [DIV_LAT];
	logic             bad_dly_q [DIV_LAT];

	assign en        = out_ready || !vld_q[LAT-1];
	assign in_ready  = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icr_q <= ICR_RESET;
			vld_q <= '0;
		end else begin
			if (cfg_we)
				icr_q <= cfg_wdata;
			if (en)
				vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	hoe_numer #(.FRAC_BITS(FRAC_BITS)) u_numer (
		.clk  (clk),
		.en   (en),
		.icr  (icr_q),
		.beat (in_data),
		.num  (num)
	);

	hoe_div u_div_x (.clk(clk), .en(en), .mag(num.mag_x), .rho(num.rho),
		.neg(num.neg[0]), .quo(u.x));
	hoe_div u_div_y (.clk(clk), .en(en), .mag(num.mag_y), .rho(num.rho),
		.neg(num.neg[1]), .quo(u.y));
	hoe_div u_div_z (.clk(clk), .en(en), .mag(num.mag_z), .rho(num.rho),
		.neg(num.neg[2]), .quo(u.z));

	always_ff @(posedge clk) begin
		if (en) begin
			b_dly_q[0]   <= num.b;
			bad_dly_q[0] <= num.bad;
			for (int k = 1; k < DIV_LAT; k++) begin
				b_dly_q[k]   <= b_dly_q[k-1];
				bad_dly_q[k] <= bad_dly_q[k-1];
			end
		end
	end

	hoe_cross #(.FRAC_BITS(FRAC_BITS)) u_cross (
		.clk (clk),
		.en  (en),
		.u   (u),
		.b   (b_dly_q[DIV_LAT-1]),
		.bad (bad_dly_q[DIV_LAT-1]),
		.res (out_data)
	);
endmodule

// ===== dv/tb_hall_ohm_electric_field_top.sv =====
// Testbench for hall_ohm_electric_field_top: random and directed grid cells,
// checked against an in-bench electric field predictor through a scoreboard.
// Depends on hoe_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_hall_ohm_electric_field_top import hoe_pkg::*; ();

	class field_scoreboard;
		out_beat_t pending_fields[$];
		logic [ICR_W-1:0] icr;
		int errors;

		function new();
			icr = ICR_RESET;
			errors = 0;
		endfunction

		function logic signed [63:0] sat(input logic signed [127:0] x);
			if (x > 128'sd2147483647)
				return 64'sd2147483647;
			if (x < -128'sd2147483648)
				return -64'sd2147483648;
			return x[63:0];
		endfunction

		function logic signed [63:0] vel(input word_t mom, input word_t cur,
			input word_t rho);
			logic signed [127:0] p, n, lim, q;
			lim = 128'sd1 <<< (62 - FRAC_BITS_DEF);
			p = $signed({1'b0, icr}) * cur;
			p = p >>> FRAC_BITS_DEF;
			n = mom - p;
			if (n > lim)
				n = lim;
			if (n < -lim)
				n = -lim;
			n = n <<< FRAC_BITS_DEF;
			q = n / rho;
			return sat(q);
		endfunction

		function word_t cross_term(input logic signed [63:0] a, input word_t b,
			input logic signed [63:0] c, input word_t d);
			logic signed [127:0] diff;
			diff = a * b - c * d;
			diff = diff >>> FRAC_BITS_DEF;
			return word_t'(sat(diff));
		endfunction

		function void note_cell(input in_beat_t c);
			out_beat_t e;
			logic signed [63:0] ux, uy, uz;
			e = '0;
			if (c.density <= 0) begin
				e.bad_density = 1'b1;
			end else begin
				ux = vel(c.mom_x, c.j_x, c.density);
				uy = vel(c.mom_y, c.j_y, c.density);
				uz = vel(c.mom_z, c.j_z, c.density);
				e.e_x = cross_term(uz, c.b_y, uy, c.b_z);
				e.e_y = cross_term(ux, c.b_z, uz, c.b_x);
				e.e_z = cross_term(uy, c.b_x, ux, c.b_y);
			end
			pending_fields.push_back(e);
		endfunction

		function void check_field(input out_beat_t got);
			out_beat_t e;
			if (pending_fields.size() == 0) begin
				$display("%0t unexpected beat %h", $time, got);
				errors++;
				return;
			end
			e = pending_fields.pop_front();
			if (got.e_x !== e.e_x)
				$display("%0t e_x exp %h got %h", $time, e.e_x, got.e_x);
			if (got.e_y !== e.e_y)
				$display("%0t e_y exp %h got %h", $time, e.e_y, got.e_y);
			if (got.e_z !== e.e_z)
				$display("%0t e_z exp %h got %h", $time, e.e_z, got.e_z);
			if (got.bad_density !== e.bad_density)
				$display("%0t bad_density exp %b got %b", $time, e.bad_density,
					got.bad_density);
			if (got !== e)
				errors++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_beat_t out_data;
	logic cfg_we = 1'b0;
	logic [ICR_W-1:0] cfg_wdata = '0;

	field_scoreboard sb = new();
	int send_idle = 0;
	int recv_stall = 0;
	int cycles = 0;

	always #4 clk = ~clk;

	hall_ohm_electric_field_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("TB_ERROR");
			$finish;
		end
		if (arst_n && out_valid && out_ready)
			sb.check_field(out_data);
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall);

	function automatic word_t rand_word();
		case ($urandom_range(5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return word_t'($urandom_range(262143)) - 32'sd131072;
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic in_beat_t rand_cell();
		in_beat_t c;
		c = {$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom};
		c.b_x = rand_word(); c.b_y = rand_word(); c.b_z = rand_word();
		c.j_x = rand_word(); c.j_y = rand_word(); c.j_z = rand_word();
		c.mom_x = rand_word(); c.mom_y = rand_word(); c.mom_z = rand_word();
		case ($urandom_range(9))
			0: c.density = 0;
			1: c.density = -word_t'($urandom_range(65536));
			2: c.density = 32'sh7fffffff;
			3: c.density = 1;
			4: c.density = word_t'($urandom);
			default: c.density = word_t'($urandom_range(1 << 20, 1));
		endcase
		return c;
	endfunction

	task automatic send_cell(input in_beat_t c);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_cell(c);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_fields.size() != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_icr(input logic [ICR_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.icr = v;
	endtask

	initial begin
		in_beat_t c;
		logic [ICR_W-1:0] icr_set[5];
		int idle_a[4];
		int stall_a[4];
		icr_set = '{31'd65536, 31'd0, 31'h7fffffff, 31'd1, 31'd12345678};
		idle_a = '{0, 74, 0, 19};
		stall_a = '{0, 0, 74, 19};
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, bad density, saturation
		c = '0; c.density = 0; send_cell(c);
		c.density = 32'sh80000000; send_cell(c);
		c = '1; send_cell(c);
		c = {10{32'sh7fffffff}}; send_cell(c);
		c = {10{32'sh80000000}}; c.density = 1; send_cell(c);
		c = {10{32'sh7fffffff}}; c.density = 1; send_cell(c);
		c = '0; c.density = 32'sh10000; c.mom_x = 32'sh10000; c.b_y = 32'sh20000;
		send_cell(c);
		c.j_z = 32'sh80000000; c.b_x = 32'sh7fffffff; send_cell(c);
		c = {10{32'h55555555}}; send_cell(c);
		c = {10{32'haaaaaaaa}}; c.density = 32'sh12345; send_cell(c);
		write_icr(31'h7fffffff);
		c = {10{32'sh80000000}}; c.density = 1; send_cell(c);
		c = {10{32'sh7fffffff}}; send_cell(c);

		for (int ph = 0; ph < 20; ph++) begin
			write_icr(icr_set[ph % 5] ^ (ph >= 5 ? 31'($urandom) : 31'd0));
			send_idle = idle_a[ph % 4];
			recv_stall = stall_a[ph % 4];
			for (int i = 0; i < 62; i++) begin
				send_cell(rand_cell());
				if (i == 30)
					drain();
			end
		end

		send_idle = 0;
		recv_stall = 0;
		drain();
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
